[design/bernoulli_kernel_product_assert.svh]
// assertion helpers for the bernoulli kernel product block
`ifndef BERNOULLI_KERNEL_PRODUCT_ASSERT_SVH
`define BERNOULLI_KERNEL_PRODUCT_ASSERT_SVH

// same-cycle implication
`define BKP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/bkp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bkp_pkg;

  localparam int CoordFracBits = 16;
  localparam int QB = 30;
  localparam int VW = 36;

  localparam logic [15:0] CoordMask = 16'((32'd1 << CoordFracBits) - 32'd1);

  localparam longint QOne  = longint'(1) << QB;
  localparam longint QHalf = QOne / 2;
  localparam longint QSixth = (QOne + 3) / 6;
  localparam longint QThirtieth = (QOne + 15) / 30;
  localparam longint QFortySecond = (QOne + 21) / 42;

  // reciprocals for exact floor division of values below 2^30
  localparam longint RecipFact24  = ((longint'(1) << 35) + 23) / 24;
  localparam longint RecipFact36  = ((longint'(1) << 36) + 35) / 36;
  localparam longint RecipFact720 = ((longint'(1) << 40) + 719) / 720;

  localparam logic signed [31:0] ProdOne = 32'sd16777216;

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        last_coord;
  } bkp_in_t;

  typedef struct packed {
    logic signed [31:0] kernel_value;
    logic               saturated;
  } bkp_out_t;

  typedef struct packed {
    logic [29:0] x_t;
    logic [29:0] y_t;
    logic [29:0] v_t;
    logic        last;
    logic [1:0]  deg;
  } bkp_job_t;

  function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] a);
    mag_of = a[VW-1] ? VW'(-a) : VW'(a);
  endfunction

  function automatic logic signed [VW-1:0] poly_init(input logic [2:0] n);
    case (n)
      3'd1:    poly_init = VW'(-QHalf);
      3'd2:    poly_init = VW'(-QOne);
      3'd3:    poly_init = VW'(-3 * QHalf);
      3'd4:    poly_init = VW'(-2 * QOne);
      3'd6:    poly_init = VW'(-3 * QOne);
      default: poly_init = '0;
    endcase
  endfunction

  function automatic logic [2:0] poly_steps(input logic [2:0] n);
    case (n)
      3'd2:    poly_steps = 3'd1;
      3'd3:    poly_steps = 3'd2;
      3'd4:    poly_steps = 3'd3;
      3'd6:    poly_steps = 3'd5;
      default: poly_steps = 3'd0;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] poly_coef(input logic [2:0] n,
                                                     input logic [2:0] k);
    logic signed [VW-1:0] c;
    c = '0;
    case (n)
      3'd2: c = VW'(QSixth);
      3'd3: if (k == 3'd0) c = VW'(QHalf);
      3'd4: begin
        if (k == 3'd0) c = VW'(QOne);
        if (k == 3'd2) c = VW'(-QThirtieth);
      end
      3'd6: begin
        if (k == 3'd0) c = VW'(5 * QHalf);
        if (k == 3'd2) c = VW'(-QHalf);
        if (k == 3'd4) c = VW'(QFortySecond);
      end
      default: c = '0;
    endcase
    poly_coef = c;
  endfunction

  function automatic logic [9:0] sq_fact(input logic [1:0] d);
    case (d)
      2'd2:    sq_fact = 10'd4;
      2'd3:    sq_fact = 10'd36;
      default: sq_fact = 10'd1;
    endcase
  endfunction

  function automatic logic [9:0] fact2(input logic [1:0] d);
    case (d)
      2'd2:    fact2 = 10'd24;
      2'd3:    fact2 = 10'd720;
      default: fact2 = 10'd2;
    endcase
  endfunction

  // divisors 1, 2 and 4 are plain shifts of one
  function automatic logic [31:0] recip_of(input logic [9:0] k);
    case (k)
      10'd24:  recip_of = 32'(RecipFact24);
      10'd36:  recip_of = 32'(RecipFact36);
      10'd720: recip_of = 32'(RecipFact720);
      default: recip_of = 32'(QOne);
    endcase
  endfunction

  function automatic logic [5:0] recip_sh(input logic [9:0] k);
    case (k)
      10'd2:   recip_sh = 6'd31;
      10'd4:   recip_sh = 6'd32;
      10'd24:  recip_sh = 6'd35;
      10'd36:  recip_sh = 6'd36;
      10'd720: recip_sh = 6'd40;
      default: recip_sh = 6'd30;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/bernoulli_kernel_product.sv]
// channel | direction | handshake             | payload
// cfg     | in        | cfg_we_i              | cfg_data_i (kernel degree)
// in      | in        | in_valid_i/in_ready_o | in_data_i (x, y, last)
// out     | out       | out_valid_o/out_ready_i | out_data_o (value, saturated)
// the back sequencer takes one item at a time from the queue and uses one
// shared 32x32 multiply per horner step, per term product,
// per reciprocal factorial division and for the running product
// a two-item queue lets the front accept while the back is busy
// reset clears the running product to one and empties queue and output
// out_data_o holds while out_valid_o is high and out_ready_i low
`timescale 1ns / 1ps
`default_nettype none
module bernoulli_kernel_product import bkp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire bkp_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bkp_out_t        out_data_o
);

  logic [1:0] deg_q;
  logic       push, full, pop, q_valid;
  bkp_job_t   push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 2'd1;
    end else if (cfg_we_i) begin
      deg_q <= cfg_data_i;
    end
  end

  bkp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_deg_i  (deg_q),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  bkp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  bkp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[design/bkp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bkp_front import bkp_pkg::*; (
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire bkp_in_t in_data_i,
  input  wire logic [1:0] cfg_deg_i,
  input  wire logic    q_full_i,
  output logic         push_o,
  output bkp_job_t     job_o
);

  logic [15:0] xm, ym, vm;

  assign in_ready_o = !q_full_i;
  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    xm = in_data_i.x_coord & CoordMask;
    ym = in_data_i.y_coord & CoordMask;
    vm = 16'(xm - ym) & CoordMask;
    job_o.x_t  = 30'(xm) << (QB - CoordFracBits);
    job_o.y_t  = 30'(ym) << (QB - CoordFracBits);
    job_o.v_t  = 30'(vm) << (QB - CoordFracBits);
    job_o.last = in_data_i.last_coord;
    job_o.deg  = (cfg_deg_i == 2'd0) ? 2'd1 : cfg_deg_i;
  end

endmodule
`default_nettype wire

[design/bkp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module bkp_queue import bkp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire bkp_job_t job_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output bkp_job_t      job_o
);

  bkp_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

[design/bkp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bkp_back import bkp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire bkp_job_t q_job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bkp_out_t      out_data_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StHInit = 4'd1;
  localparam logic [3:0] StHMul  = 4'd2;
  localparam logic [3:0] StHAdd  = 4'd3;
  localparam logic [3:0] StHDone = 4'd4;
  localparam logic [3:0] StPMul  = 4'd5;
  localparam logic [3:0] StPRnd  = 4'd6;
  localparam logic [3:0] StDSt   = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StFMul  = 4'd9;
  localparam logic [3:0] StFRnd  = 4'd10;
  localparam logic [3:0] StDRes  = 4'd11;

  localparam logic [1:0] SelX = 2'd0;
  localparam logic [1:0] SelY = 2'd1;
  localparam logic [1:0] SelV = 2'd2;

  localparam logic signed [VW-1:0] SatHi = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] SatLo = VW'(-64'sd2147483648);

  logic [3:0]           state_q, state_d;
  bkp_job_t             job_q, job_d;
  logic [1:0]           d_q, d_d, sel_q, sel_d;
  logic [2:0]           k_q, k_d;
  logic signed [VW-1:0] acc_q, acc_d, bx_q, bx_d, s_q, s_d;
  logic [63:0]          prod_q, prod_d;
  logic                 neg_q, neg_d;
  logic signed [31:0]   rp_q, rp_d;
  logic                 clip_q, clip_d;
  logic                 tail_q, tail_d, dsign_q, dsign_d;
  logic [31:0]          num_q, num_d;
  logic [9:0]           dvsr_q, dvsr_d;
  bkp_out_t             out_q, out_d;
  logic                 ov_q, ov_d;

  logic [2:0]           pn;
  logic signed [VW-1:0] t_s, rnd_s, qv, r;
  logic [63:0]          rsum, quo;
  logic                 sat;

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign pop_o = (state_q == StIdle) && q_valid_i;

  always_comb begin
    pn = (sel_q == SelV) ? 3'({job_q.deg, 1'b0}) : 3'(d_q);
    case (sel_q)
      SelX:    t_s = VW'(job_q.x_t);
      SelY:    t_s = VW'(job_q.y_t);
      default: t_s = VW'(job_q.v_t);
    endcase
    rsum  = prod_q + (64'd1 << (QB - 1));
    rnd_s = neg_q ? -VW'(rsum[63:QB]) : VW'(rsum[63:QB]);
    quo   = prod_q >> recip_sh(dvsr_q);
    r   = rnd_s;
    sat = (r > SatHi) || (r < SatLo);

    state_d = state_q; job_d = job_q; d_d = d_q; sel_d = sel_q; k_d = k_q;
    acc_d = acc_q; bx_d = bx_q; s_d = s_q; prod_d = prod_q; neg_d = neg_q;
    rp_d = rp_q; clip_d = clip_q; tail_d = tail_q; dsign_d = dsign_q;
    num_d = num_q; dvsr_d = dvsr_q;
    out_d = out_q;
    ov_d = ov_q && !out_ready_i;
    qv = '0;

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          job_d = q_job_i;
          d_d = 2'd1;
          sel_d = SelX;
          s_d = VW'(QOne);
          state_d = StHInit;
        end
      end
      StHInit: begin
        acc_d = t_s + poly_init(pn);
        k_d = 3'd0;
        state_d = (poly_steps(pn) == 3'd0) ? StHDone : StHMul;
      end
      StHMul: begin
        prod_d = 64'(32'(mag_of(t_s))) * 64'(32'(mag_of(acc_q)));
        neg_d = acc_q[VW-1];
        state_d = StHAdd;
      end
      StHAdd: begin
        acc_d = rnd_s + poly_coef(pn, k_q);
        k_d = k_q + 3'd1;
        state_d = ((k_q + 3'd1) == poly_steps(pn)) ? StHDone : StHMul;
      end
      StHDone: begin
        case (sel_q)
          SelX: begin
            bx_d = acc_q;
            sel_d = SelY;
            state_d = StHInit;
          end
          SelY: state_d = StPMul;
          default: begin
            tail_d = 1'b1;
            dvsr_d = fact2(job_q.deg);
            state_d = StDSt;
          end
        endcase
      end
      StPMul: begin
        prod_d = 64'(32'(mag_of(bx_q))) * 64'(32'(mag_of(acc_q)));
        neg_d = bx_q[VW-1] ^ acc_q[VW-1];
        state_d = StPRnd;
      end
      StPRnd: begin
        acc_d = rnd_s;
        tail_d = 1'b0;
        dvsr_d = sq_fact(d_q);
        state_d = StDSt;
      end
      StDSt: begin
        // dividends stay below 2^30, where the reciprocal is exact
        num_d = 32'(mag_of(acc_q)) + 32'(dvsr_q >> 1);
        dsign_d = acc_q[VW-1];
        state_d = StDiv;
      end
      StDiv: begin
        prod_d = 64'(num_q) * 64'(recip_of(dvsr_q));
        state_d = StDRes;
      end
      StDRes: begin
        qv = dsign_q ? -VW'(quo) : VW'(quo);
        if (tail_q) begin
          s_d = job_q.deg[0] ? (s_q + qv) : (s_q - qv);
          state_d = StFMul;
        end else begin
          s_d = s_q + qv;
          sel_d = SelX;
          if (d_q == job_q.deg) begin
            sel_d = SelV;
          end else begin
            d_d = d_q + 2'd1;
          end
          state_d = StHInit;
        end
      end
      StFMul: begin
        prod_d = 64'(32'(mag_of(VW'(rp_q)))) * 64'(32'(mag_of(s_q)));
        neg_d = rp_q[31] ^ s_q[VW-1];
        state_d = StFRnd;
      end
      StFRnd: begin
        if (!(job_q.last && ov_q && !out_ready_i)) begin
          if (job_q.last) begin
            out_d.kernel_value = sat ? (r[VW-1] ? SatLo[31:0] : SatHi[31:0]) : r[31:0];
            out_d.saturated = clip_q | sat;
            ov_d = 1'b1;
            rp_d = ProdOne;
            clip_d = 1'b0;
          end else begin
            rp_d = sat ? (r[VW-1] ? SatLo[31:0] : SatHi[31:0]) : r[31:0];
            clip_d = clip_q | sat;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; d_q <= d_d; sel_q <= sel_d; k_q <= k_d;
    acc_q <= acc_d; bx_q <= bx_d; s_q <= s_d; prod_q <= prod_d; neg_q <= neg_d;
    tail_q <= tail_d; dsign_q <= dsign_d; num_q <= num_d;
    dvsr_q <= dvsr_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rp_q <= ProdOne;
      clip_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q <= rp_d;
      clip_q <= clip_d;
      ov_q <= ov_d;
    end
  end

endmodule
`default_nettype wire

[design/bkp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bernoulli_kernel_product_assert.svh"
module bkp_checker import bkp_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire bkp_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire bkp_out_t out_data_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_last, out_acc;

  assign in_last = in_valid_i && in_ready_o && in_data_i.last_coord;
  assign out_acc = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + 3'(in_last) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BKP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")
  `BKP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "out item changed")
  `BKP_ASSERT_NOW(a_no_invent, clk_i, rst_ni, out_valid_o, pend_q != 3'd0, "result without last item")
  `BKP_ASSERT_NOW(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q <= 3'd4, "too many items in flight")

endmodule

bind bernoulli_kernel_product bkp_checker u_bkp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
